[sv/icmp_erc_pkg.sv]
package icmp_erc_pkg;

	// packet layout
	localparam int MAX_PACKET_BYTES_DEF = 2048;
	localparam int TIMESTAMP_BYTES = 16;
	localparam int ICMP_HDR_LEN = 8;
	localparam logic [7:0] FILL_BYTE = 8'hA5;
	localparam int ICMP_BYTES_MAX = 2047;

	// field widths
	localparam int ID_W = 16;
	localparam int SEQ_W = 16;
	localparam int LEN_W = 11;
	localparam int STATUS_W = 3;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_EXP_ID = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_EXP_SEQ = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_ECHO_LEN = 2'd2;

	// register reset values
	localparam logic [ID_W-1:0] EXP_ID_RST = 16'd0;
	localparam logic [SEQ_W-1:0] EXP_SEQ_RST = 16'd1;
	localparam logic [LEN_W-1:0] ECHO_LEN_RST = 11'd64;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_REPLY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_SEQ = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_FILL = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0] expected_identifier;
		logic [SEQ_W-1:0] expected_sequence;
		logic [LEN_W-1:0] echo_length;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [7:0] ttl_value;
		logic [LEN_W-1:0] icmp_bytes;
	} result_t;

endpackage

[sv/icmp_erc_cfg.sv]
module icmp_erc_cfg (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [icmp_erc_pkg::CFG_ADDR_W-1:0] addr,
	input logic [icmp_erc_pkg::CFG_DATA_W-1:0] wdata,
	output icmp_erc_pkg::cfg_t cfg
);
	import icmp_erc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_identifier <= EXP_ID_RST;
			cfg_q.expected_sequence <= EXP_SEQ_RST;
			cfg_q.echo_length <= ECHO_LEN_RST;
		end else if (wr_en) begin
			case (addr)
				CFG_EXP_ID: begin
					cfg_q.expected_identifier <= wdata[ID_W-1:0];
				end
				CFG_EXP_SEQ: begin
					cfg_q.expected_sequence <= wdata[SEQ_W-1:0];
				end
				CFG_ECHO_LEN: begin
					cfg_q.echo_length <= wdata[LEN_W-1:0];
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/icmp_erc_core.sv]
module icmp_erc_core #(
	parameter int MAX_PACKET_BYTES = icmp_erc_pkg::MAX_PACKET_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [7:0] data_byte,
	input logic last_byte,
	input icmp_erc_pkg::cfg_t cfg,
	output icmp_erc_pkg::result_t result
);
	import icmp_erc_pkg::*;

	localparam int IDX_W = $clog2(MAX_PACKET_BYTES);
	localparam int CW = (IDX_W + 2 > 12) ? IDX_W + 2 : 12;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PACKET_BYTES - 1);

	logic [IDX_W-1:0] idx_q;
	logic [5:0] hdr_q;
	logic [7:0] ttl_q;
	logic [7:0] type_q;
	logic [ID_W-1:0] id_q;
	logic [SEQ_W-1:0] seq_q;
	logic bad_q;

	logic [5:0] hdr_nx;
	logic [7:0] ttl_nx;
	logic [7:0] type_nx;
	logic [ID_W-1:0] id_nx;
	logic [SEQ_W-1:0] seq_nx;
	logic bad_nx;

	logic [CW-1:0] pos_w;
	logic [CW-1:0] h_w;
	logic [CW-1:0] count_w;
	logic [CW-1:0] icmp_raw;

	assign pos_w = CW'(idx_q);
	assign hdr_nx = (idx_q == '0) ? {data_byte[3:0], 2'b00} : hdr_q;
	assign h_w = CW'(hdr_nx);
	assign ttl_nx = (pos_w == CW'(8)) ? data_byte : ttl_q;

	// icmp header capture, then fill check past the timestamp
	always_comb begin
		type_nx = type_q;
		id_nx = id_q;
		seq_nx = seq_q;
		bad_nx = bad_q;
		if (pos_w == h_w) begin
			type_nx = data_byte;
		end else if (pos_w == h_w + CW'(4)) begin
			id_nx = {data_byte, id_q[7:0]};
		end else if (pos_w == h_w + CW'(5)) begin
			id_nx = {id_q[15:8], data_byte};
		end else if (pos_w == h_w + CW'(6)) begin
			seq_nx = {data_byte, seq_q[7:0]};
		end else if (pos_w == h_w + CW'(7)) begin
			seq_nx = {seq_q[15:8], data_byte};
		end else if (pos_w >= h_w + CW'(ICMP_HDR_LEN + TIMESTAMP_BYTES)
				&& data_byte != FILL_BYTE) begin
			bad_nx = 1'b1;
		end
	end

	assign count_w = pos_w + CW'(1);
	assign icmp_raw = (count_w > h_w) ? count_w - h_w : '0;

	always_comb begin
		result.ttl_value = ttl_nx;
		result.icmp_bytes = (icmp_raw > CW'(ICMP_BYTES_MAX)) ? LEN_W'(ICMP_BYTES_MAX)
			: icmp_raw[LEN_W-1:0];
		if (id_nx != cfg.expected_identifier) begin
			result.status = ST_BAD_ID;
		end else if (count_w < CW'(cfg.echo_length) + h_w) begin
			result.status = ST_SHORT;
		end else if (type_nx != 8'd0) begin
			result.status = ST_NOT_REPLY;
		end else if (seq_nx != cfg.expected_sequence) begin
			result.status = ST_BAD_SEQ;
		end else if (bad_nx) begin
			result.status = ST_BAD_FILL;
		end else begin
			result.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hdr_q <= '0;
			ttl_q <= '0;
			type_q <= '0;
			id_q <= '0;
			seq_q <= '0;
			bad_q <= 1'b0;
		end else if (fire) begin
			if (last_byte) begin
				idx_q <= '0;
				hdr_q <= '0;
				ttl_q <= '0;
				type_q <= '0;
				id_q <= '0;
				seq_q <= '0;
				bad_q <= 1'b0;
			end else begin
				if (idx_q != IDX_LAST) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				hdr_q <= hdr_nx;
				ttl_q <= ttl_nx;
				type_q <= type_nx;
				id_q <= id_nx;
				seq_q <= seq_nx;
				bad_q <= bad_nx;
			end
		end
	end

endmodule

[sv/icmp_echo_reply_checker.sv]
// icmp echo reply checker
//
// input channel: one byte of a received ipv4 packet per transaction, starting
// at the first ip header byte; last_byte marks the final byte. in_valid and
// in_stall handshake, a transaction moves when in_valid is high and in_stall
// is low.
// output channel: one status transaction per packet (status, ttl_value,
// icmp_bytes), held on the ports while out_stall is high.
// config port: cfg_wr_en with cfg_addr 0 expected identifier, 1 expected
// sequence, 2 echo length; write only while no packet is in flight.
// result: the accepted last byte sits in the input register, and its result
// is captured in the result register. throughput: one byte per cycle while
// in_stall is low, set by the single parse stage between the two registers.
// stall: a pending last byte waits in the input register while the output
// is stalled, and in_stall rises only then; other bytes keep flowing.
// reset: all packet state clears, registers take their reset values, and
// both registers drop valid.
module icmp_echo_reply_checker #(
	parameter int MAX_PACKET_BYTES = icmp_erc_pkg::MAX_PACKET_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [icmp_erc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input logic [icmp_erc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [icmp_erc_pkg::STATUS_W-1:0] status,
	output logic [7:0] ttl_value,
	output logic [icmp_erc_pkg::LEN_W-1:0] icmp_bytes
);
	import icmp_erc_pkg::*;

	cfg_t cfg;
	result_t res;

	// input register
	logic valid_s1;
	logic [7:0] data_s1;
	logic last_s1;

	// result register
	logic out_valid_q;
	result_t res_q;

	logic in_fire;
	logic out_free;
	logic fire_s1;

	assign out_free = !out_valid_q || !out_stall;
	// a byte that ends no packet never waits on the output side
	assign fire_s1 = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !fire_s1;
	assign in_fire = in_valid && !in_stall;

	icmp_erc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_wr_en),
		.addr(cfg_addr),
		.wdata(cfg_wdata),
		.cfg(cfg)
	);

	icmp_erc_core #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire_s1),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.cfg(cfg),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !fire_s1);
		end
	end

	// payload of the input register, loaded on every accepted transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign ttl_value = res_q.ttl_value;
	assign icmp_bytes = res_q.icmp_bytes;

endmodule

[sv/icmp_erc_checker.sv]
module icmp_erc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [icmp_erc_pkg::STATUS_W-1:0] status,
	input logic [7:0] ttl_value,
	input logic [icmp_erc_pkg::LEN_W-1:0] icmp_bytes
);
	import icmp_erc_pkg::*;

	// input side backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_BAD_FILL))
		else $error("status code out of range");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			($stable(status) && $stable(ttl_value) && $stable(icmp_bytes)))
		else $error("result changed while stalled");

endmodule

bind icmp_echo_reply_checker icmp_erc_checker u_icmp_erc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.ttl_value(ttl_value),
	.icmp_bytes(icmp_bytes)
);
